### hdl/ascs_pkg.sv
// ----------------------------------------------------------------------------
// ascs_pkg
// Shared types and constants for the converter scan sequencer.
// ----------------------------------------------------------------------------
package ascs_pkg;

    localparam int CHAN_W     = 5;
    localparam int WAIT_W     = 4;
    localparam int CODE_W     = 16;
    localparam int TOTAL_W    = 32;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 128;

    localparam logic [CMD_W-1:0] CMD_RECLAIM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KICK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POLL    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AI_CHAN_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AI_CHAN_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AI_CHAN_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_CHAN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_WAIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 3'd6;

    localparam logic [CHAN_W-1:0] RST_AI_CHAN_0     = 5'd16;
    localparam logic [CHAN_W-1:0] RST_AI_CHAN_1     = 5'd17;
    localparam logic [CHAN_W-1:0] RST_AI_CHAN_2     = 5'd18;
    localparam logic [CHAN_W-1:0] RST_FB_CHAN       = 5'd19;
    localparam logic [WAIT_W-1:0] RST_START_WAIT    = 4'd3;
    localparam logic [WAIT_W-1:0] RST_TIMEOUT_LIMIT = 4'd8;

    localparam logic [WAIT_W-1:0] WAIT_MAX = 4'hF;

    typedef struct packed {
        logic              enable;
        logic [CHAN_W-1:0] ai_chan_0;
        logic [CHAN_W-1:0] ai_chan_1;
        logic [CHAN_W-1:0] ai_chan_2;
        logic [CHAN_W-1:0] fb_chan;
        logic [WAIT_W-1:0] start_wait;
        logic [WAIT_W-1:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic               start_valid;
        logic [CHAN_W-1:0]  start_channel;
        logic               sample_valid;
        logic [1:0]         sample_slot;
        logic [CODE_W-1:0]  sample_code;
        logic               avg_valid;
        logic [CODE_W-1:0]  avg_code;
        logic [CODE_W-1:0]  avg_last_raw;
        logic               timed_out;
        logic [TOTAL_W-1:0] done_total;
        logic [TOTAL_W-1:0] timeout_total;
    } res_t;

endpackage

### hdl/adc_scan_sequencer_with_average_unit.sv
// ----------------------------------------------------------------------------
// adc_scan_sequencer_with_average_unit
// Tick-driven converter scan sequencer with feedback averaging.
// ----------------------------------------------------------------------------
// channel  | dir | beat contents
// s_axis   | in  | command, conv_done, conv_data
// m_axis   | out | start, sample, average, timeout flags and running totals
// cfg_wr   | in  | register index and data, one write per enabled edge
//
// One beat per cycle sustained while m_axis is not stalled; a beat's result
// passes through the input register, result register and output register
// before it is offered on m_axis.
// A stall holds every stage in place, up to three beats in flight; tready
// chains back combinationally so no bubble is lost.
// Reset (aresetn low, synchronous) clears all sequencer state and valid flags.
// ----------------------------------------------------------------------------
module adc_scan_sequencer_with_average_unit #(
    parameter int AVG_COUNT    = 16,
    parameter int DIRECT_SLOTS = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // command[1:0], conv_done[2], conv_data[18:3], zero pad
    input  logic [ascs_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // start_valid, start_channel, sample_valid, sample_slot, sample_code,
    // avg_valid, avg_code, avg_last_raw, timed_out, done_total,
    // timeout_total, zero pad
    output logic [ascs_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [ascs_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [ascs_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    localparam int SUM_W = 16 + $clog2(AVG_COUNT);
    localparam int IN_W  = ascs_pkg::CMD_W + 1 + ascs_pkg::CODE_W;

    ascs_pkg::cfg_t          cfg;
    logic                    in_valid_reg;
    logic [IN_W-1:0]         in_data_reg;
    logic                    core_ready;
    logic                    mid_valid;
    ascs_pkg::res_t          mid_res;
    logic [SUM_W-1:0]        mid_sum;
    logic                    mid_ready;
    ascs_pkg::res_t          out_res;

    assign s_tready = !in_valid_reg || core_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_data_reg <= s_tdata[IN_W-1:0];
        end
    end

    ascs_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    ascs_core #(
        .AVG_COUNT    (AVG_COUNT),
        .DIRECT_SLOTS (DIRECT_SLOTS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_cmd    (in_data_reg[1:0]),
        .in_done   (in_data_reg[2]),
        .in_data   (in_data_reg[18:3]),
        .in_ready  (core_ready),
        .mid_valid (mid_valid),
        .mid_res   (mid_res),
        .mid_sum   (mid_sum),
        .mid_ready (mid_ready)
    );

    ascs_avg #(
        .AVG_COUNT (AVG_COUNT)
    ) u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mid_valid (mid_valid),
        .mid_res   (mid_res),
        .mid_sum   (mid_sum),
        .mid_ready (mid_ready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {5'd0,
                      out_res.timeout_total,
                      out_res.done_total,
                      out_res.timed_out,
                      out_res.avg_last_raw,
                      out_res.avg_code,
                      out_res.avg_valid,
                      out_res.sample_code,
                      out_res.sample_slot,
                      out_res.sample_valid,
                      out_res.start_channel,
                      out_res.start_valid};

endmodule

### hdl/ascs_cfg.sv
// ----------------------------------------------------------------------------
// ascs_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module ascs_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ascs_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [ascs_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output ascs_pkg::cfg_t                   cfg
);

    ascs_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.ai_chan_0     <= ascs_pkg::RST_AI_CHAN_0;
            cfg_reg.ai_chan_1     <= ascs_pkg::RST_AI_CHAN_1;
            cfg_reg.ai_chan_2     <= ascs_pkg::RST_AI_CHAN_2;
            cfg_reg.fb_chan       <= ascs_pkg::RST_FB_CHAN;
            cfg_reg.start_wait    <= ascs_pkg::RST_START_WAIT;
            cfg_reg.timeout_limit <= ascs_pkg::RST_TIMEOUT_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                ascs_pkg::REG_ENABLE:        cfg_reg.enable        <= cfg_wr_data[0];
                ascs_pkg::REG_AI_CHAN_0:     cfg_reg.ai_chan_0     <= cfg_wr_data;
                ascs_pkg::REG_AI_CHAN_1:     cfg_reg.ai_chan_1     <= cfg_wr_data;
                ascs_pkg::REG_AI_CHAN_2:     cfg_reg.ai_chan_2     <= cfg_wr_data;
                ascs_pkg::REG_FB_CHAN:       cfg_reg.fb_chan       <= cfg_wr_data;
                ascs_pkg::REG_START_WAIT:    cfg_reg.start_wait    <= cfg_wr_data[3:0];
                ascs_pkg::REG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/ascs_core.sv
// ----------------------------------------------------------------------------
// ascs_core
// Sequencer state and per-beat command logic, with the result register.
// ----------------------------------------------------------------------------
module ascs_core #(
    parameter int AVG_COUNT    = 16,
    parameter int DIRECT_SLOTS = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ascs_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    input  logic [ascs_pkg::CMD_W-1:0]        in_cmd,
    input  logic                              in_done,
    input  logic [ascs_pkg::CODE_W-1:0]       in_data,
    output logic                              in_ready,
    output logic                              mid_valid,
    output ascs_pkg::res_t                    mid_res,
    output logic [16+$clog2(AVG_COUNT)-1:0]   mid_sum,
    input  logic                              mid_ready
);

    localparam int SLOT_W = $clog2(DIRECT_SLOTS + 1);
    localparam int SUM_W  = 16 + $clog2(AVG_COUNT);
    localparam int CNT_W  = $clog2(AVG_COUNT + 1);

    logic [SLOT_W-1:0]                 next_slot_reg, next_slot_next;
    logic [SLOT_W-1:0]                 active_slot_reg, active_slot_next;
    logic                              pending_reg, pending_next;
    logic [ascs_pkg::WAIT_W-1:0]       wait_count_reg, wait_count_next;
    logic [SUM_W-1:0]                  fb_sum_reg, fb_sum_next;
    logic [CNT_W-1:0]                  fb_count_reg, fb_count_next;
    logic [ascs_pkg::TOTAL_W-1:0]      done_counter_reg, done_counter_next;
    logic [ascs_pkg::TOTAL_W-1:0]      timeout_counter_reg, timeout_counter_next;

    logic                              mid_valid_reg;
    ascs_pkg::res_t                    mid_res_reg;
    logic [SUM_W-1:0]                  mid_sum_reg;

    ascs_pkg::res_t                    res;
    logic [SUM_W-1:0]                  fb_total;
    logic                              take;

    function automatic logic [ascs_pkg::CHAN_W-1:0] slot_channel(
        input logic [SLOT_W-1:0] slot,
        input ascs_pkg::cfg_t    c
    );
        logic [ascs_pkg::CHAN_W-1:0] ch;
        if (slot >= SLOT_W'(DIRECT_SLOTS)) begin
            ch = c.fb_chan;
        end else if (slot == SLOT_W'(0)) begin
            ch = c.ai_chan_0;
        end else if (slot == SLOT_W'(1)) begin
            ch = c.ai_chan_1;
        end else begin
            ch = c.ai_chan_2;
        end
        return ch;
    endfunction

    assign in_ready = !mid_valid_reg || mid_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        logic do_reclaim;
        logic do_kick;
        next_slot_next       = next_slot_reg;
        active_slot_next     = active_slot_reg;
        pending_next         = pending_reg;
        wait_count_next      = wait_count_reg;
        fb_sum_next          = fb_sum_reg;
        fb_count_next        = fb_count_reg;
        done_counter_next    = done_counter_reg;
        timeout_counter_next = timeout_counter_reg;
        res                  = '0;
        fb_total             = '0;
        do_reclaim = (in_cmd == ascs_pkg::CMD_RECLAIM) || (in_cmd == ascs_pkg::CMD_POLL);
        do_kick    = (in_cmd == ascs_pkg::CMD_KICK) || (in_cmd == ascs_pkg::CMD_POLL);

        if (cfg.enable) begin
            if (do_reclaim && pending_next) begin
                if (wait_count_next < cfg.start_wait) begin
                    wait_count_next = wait_count_next + 4'd1;
                end else if (in_done) begin
                    if (active_slot_next < SLOT_W'(DIRECT_SLOTS)) begin
                        res.sample_valid = 1'b1;
                        res.sample_slot  = 2'(active_slot_next);
                        res.sample_code  = in_data;
                    end else begin
                        fb_sum_next   = fb_sum_next + SUM_W'(in_data);
                        fb_count_next = fb_count_next + CNT_W'(1);
                        if (fb_count_next == CNT_W'(AVG_COUNT)) begin
                            res.avg_valid    = 1'b1;
                            res.avg_last_raw = in_data;
                            fb_total         = fb_sum_next;
                            fb_sum_next      = '0;
                            fb_count_next    = '0;
                        end
                    end
                    pending_next      = 1'b0;
                    done_counter_next = done_counter_next + 32'd1;
                end else begin
                    if (wait_count_next < ascs_pkg::WAIT_MAX) begin
                        wait_count_next = wait_count_next + 4'd1;
                    end
                    if (wait_count_next >= cfg.timeout_limit) begin
                        timeout_counter_next = timeout_counter_next + 32'd1;
                        pending_next         = 1'b0;
                        res.timed_out        = 1'b1;
                    end
                end
            end
            if (do_kick && !pending_next) begin
                res.start_valid   = 1'b1;
                res.start_channel = slot_channel(next_slot_next, cfg);
                active_slot_next  = next_slot_next;
                if (next_slot_next == SLOT_W'(DIRECT_SLOTS)) begin
                    next_slot_next = '0;
                end else begin
                    next_slot_next = next_slot_next + SLOT_W'(1);
                end
                pending_next    = 1'b1;
                wait_count_next = '0;
            end
        end
        res.done_total    = done_counter_next;
        res.timeout_total = timeout_counter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_slot_reg       <= '0;
            active_slot_reg     <= '0;
            pending_reg         <= 1'b0;
            wait_count_reg      <= '0;
            fb_sum_reg          <= '0;
            fb_count_reg        <= '0;
            done_counter_reg    <= '0;
            timeout_counter_reg <= '0;
            mid_valid_reg       <= 1'b0;
        end else begin
            if (take) begin
                next_slot_reg       <= next_slot_next;
                active_slot_reg     <= active_slot_next;
                pending_reg         <= pending_next;
                wait_count_reg      <= wait_count_next;
                fb_sum_reg          <= fb_sum_next;
                fb_count_reg        <= fb_count_next;
                done_counter_reg    <= done_counter_next;
                timeout_counter_reg <= timeout_counter_next;
            end
            if (in_ready) begin
                mid_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            mid_res_reg <= res;
            mid_sum_reg <= fb_total;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid_res   = mid_res_reg;
    assign mid_sum   = mid_sum_reg;

    a_fb_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fb_count_reg < CNT_W'(AVG_COUNT))
        else $error("feedback count reached average length");

    a_one_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_valid_reg |-> !(mid_res_reg.timed_out &&
                            (mid_res_reg.sample_valid || mid_res_reg.avg_valid)))
        else $error("timeout flagged together with a delivered code");

    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(take)) |-> $stable(done_counter_reg))
        else $error("completion count moved without a beat");

endmodule

### hdl/ascs_avg.sv
// ----------------------------------------------------------------------------
// ascs_avg
// Feedback mean by reciprocal multiply, and the output register.
// ----------------------------------------------------------------------------
module ascs_avg #(
    parameter int AVG_COUNT = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              mid_valid,
    input  ascs_pkg::res_t                    mid_res,
    input  logic [16+$clog2(AVG_COUNT)-1:0]   mid_sum,
    output logic                              mid_ready,
    output logic                              out_valid,
    output ascs_pkg::res_t                    out_res,
    input  logic                              out_ready
);

    localparam int SUM_W   = 16 + $clog2(AVG_COUNT);
    localparam int SHIFT   = SUM_W + $clog2(AVG_COUNT);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));

    logic                   out_valid_reg;
    ascs_pkg::res_t         out_res_reg;
    logic [PROD_W-1:0]      product;
    ascs_pkg::res_t         res_next;

    // exact floor(sum / AVG_COUNT) for any sum below 2^SUM_W
    assign product = PROD_W'(mid_sum) * PROD_W'(RECIP);

    always_comb begin
        res_next          = mid_res;
        res_next.avg_code = mid_res.avg_valid ? product[SHIFT +: ascs_pkg::CODE_W] : '0;
    end

    assign mid_ready = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mid_ready) begin
            out_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_ready) begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule
